[rtl/mxp_pkg.sv]
// Package for the maximum-XOR pair trie block: sizes, node link types, sequencer states.
// No dependencies; every other file uses it.
package mxp_pkg;

  localparam int WORD_BITS = 20;
  localparam int NODE_POOL = 262144;
  localparam int NODE_BITS = $clog2(NODE_POOL);
  localparam int CNT_BITS  = NODE_BITS + 1;
  localparam int LEN_BITS  = 5;
  localparam int LEN_MIN   = 3;
  localparam int LEN_RESET = 20;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [NODE_BITS-1:0] node_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [LEN_BITS-1:0]  len_t;

  typedef struct packed {
    node_t one;
    node_t zero;
  } links_t;

  typedef struct packed {
    logic   en;
    node_t  addr;
    links_t data;
  } ram_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_INSERT,
    ST_QSTART,
    ST_QUERY,
    ST_DONE
  } state_t;

endpackage

[rtl/mxp_stream_if.sv]
// Valid/ready channel interfaces for input words and best-pair results.
// Depends on mxp_pkg.
interface mxp_in_if;
  logic               valid;
  logic               ready;
  logic [mxp_pkg::WORD_BITS-1:0] word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface mxp_out_if;
  logic               valid;
  logic               ready;
  logic [mxp_pkg::WORD_BITS-1:0] best_first;
  logic [mxp_pkg::WORD_BITS-1:0] best_second;
  logic [mxp_pkg::WORD_BITS-1:0] best_xor;
  logic               pool_full;

  modport source (output valid, output best_first, output best_second, output best_xor,
                  output pool_full, input ready);
  modport sink   (input valid, input best_first, input best_second, input best_xor,
                  input pool_full, output ready);
endinterface

[rtl/max_xor_pair_trie.sv]
// Maximum-XOR pair finder over a binary trie: one word in, one best-pair beat out.
// The effective length L is the length register clamped to 3..20;
// one node-memory read per trie level, for the insert walk and then the greedy query.
// No new word is taken until the previous word is through; a word is taken while a result beat waits.
// Reset is synchronous: the root lives in flip-flops, so the node pool needs no clearing pass.
// Depends on mxp_pkg, mxp_stream_if and mxp_node_ram.
module max_xor_pair_trie (
  input  logic                           clk,
  input  logic                           rst_n,
  mxp_in_if.sink                         in_ch,
  mxp_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [mxp_pkg::LEN_BITS-1:0]   cfg_wdata
);
  import mxp_pkg::*;

  state_t state_r, state_nxt;
  len_t   len_cfg_r, len_cfg_nxt;
  word_t  w_r, w_nxt;
  node_t  cur_r, cur_nxt;
  len_t   depth_r, depth_nxt;
  cnt_t   cnt_r, cnt_nxt;
  links_t root_r, root_nxt;
  word_t  partner_r, partner_nxt;
  logic   drop_r, drop_nxt;
  logic   match_r, match_nxt;
  logic   best_valid_r, best_valid_nxt;
  word_t  best_first_r, best_first_nxt;
  word_t  best_second_r, best_second_nxt;
  word_t  best_xor_r, best_xor_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_drop_r, out_drop_nxt;

  ram_wr_t ram_wr;
  node_t   ram_raddr;
  links_t  ram_rdata;

  len_t   eff_len;
  word_t  len_mask;
  len_t   bit_idx;
  len_t   nbit_idx;
  links_t links;
  logic   cbit;
  logic   nbit;
  node_t  same_child;
  node_t  opp_child;
  logic   at_end;
  logic   last_level;
  len_t   need;
  logic [CNT_BITS:0] need_sum;
  logic   fits;
  logic   take;
  node_t  take_child;
  logic   dead_end;
  logic   in_fire;
  logic   done_fire;
  word_t  cand_xor;
  logic   better;
  links_t fresh_links;
  links_t parent_links;

  mxp_node_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (len_cfg_r < len_t'(LEN_MIN)) begin
      eff_len = len_t'(LEN_MIN);
    end else if (len_cfg_r > len_t'(WORD_BITS)) begin
      eff_len = len_t'(WORD_BITS);
    end else begin
      eff_len = len_cfg_r;
    end
  end

  assign len_mask   = ~({WORD_BITS{1'b1}} << eff_len);
  assign bit_idx    = eff_len - len_t'(1) - depth_r;
  assign nbit_idx   = eff_len - len_t'(2) - depth_r;
  assign links      = (cur_r == '0) ? root_r : ram_rdata;
  assign cbit       = w_r[bit_idx];
  assign nbit       = w_r[nbit_idx];
  assign same_child = cbit ? links.one : links.zero;
  assign opp_child  = cbit ? links.zero : links.one;
  assign at_end     = (depth_r == eff_len);
  assign last_level = (depth_r == eff_len - len_t'(1));
  assign need       = eff_len - depth_r;
  assign need_sum   = (CNT_BITS+1)'(cnt_r) + (CNT_BITS+1)'(need);
  assign fits       = (need_sum <= (CNT_BITS+1)'(NODE_POOL));
  assign take       = (opp_child != '0) ? ~cbit : cbit;
  assign take_child = (opp_child != '0) ? opp_child : same_child;
  assign dead_end   = (opp_child == '0) && (same_child == '0);
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign done_fire  = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  assign cand_xor   = (w_r ^ partner_r) & len_mask;
  assign better     = match_r && (!best_valid_r || cand_xor > best_xor_r);

  always_comb begin
    fresh_links = '0;
    if (!last_level) begin
      if (nbit) begin
        fresh_links.one = node_t'(cnt_r + cnt_t'(1));
      end else begin
        fresh_links.zero = node_t'(cnt_r + cnt_t'(1));
      end
    end
    parent_links = links;
    if (cbit) begin
      parent_links.one = node_t'(cnt_r);
    end else begin
      parent_links.zero = node_t'(cnt_r);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        if (at_end || same_child == '0) begin
          if (!fits || at_end) begin
            state_nxt = ST_QSTART;
          end else begin
            state_nxt = ST_INSERT;
          end
        end
      end
      ST_INSERT: begin
        if (last_level) begin
          state_nxt = ST_QSTART;
        end
      end
      ST_QSTART: begin
        if (root_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_QUERY;
        end
      end
      ST_QUERY: begin
        if (at_end || dead_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (done_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    len_cfg_nxt     = len_cfg_r;
    w_nxt           = w_r;
    cur_nxt         = cur_r;
    depth_nxt       = depth_r;
    cnt_nxt         = cnt_r;
    root_nxt        = root_r;
    partner_nxt     = partner_r;
    drop_nxt        = drop_r;
    match_nxt       = match_r;
    best_valid_nxt  = best_valid_r;
    best_first_nxt  = best_first_r;
    best_second_nxt = best_second_r;
    best_xor_nxt    = best_xor_r;
    out_drop_nxt    = out_drop_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    ram_wr          = '0;
    ram_raddr       = same_child;
    in_ch.ready     = (state_r == ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          w_nxt     = in_ch.word & len_mask;
          cur_nxt   = '0;
          depth_nxt = '0;
          drop_nxt  = 1'b0;
        end
      end
      ST_FIND: begin
        if (!at_end && same_child != '0) begin
          cur_nxt   = same_child;
          depth_nxt = depth_r + len_t'(1);
        end else if (!fits) begin
          drop_nxt = 1'b1;
        end else if (!at_end) begin
          if (cur_r == '0) begin
            root_nxt = parent_links;
          end else begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = cur_r;
            ram_wr.data = parent_links;
          end
        end
      end
      ST_INSERT: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = node_t'(cnt_r);
        ram_wr.data = fresh_links;
        cnt_nxt     = cnt_r + cnt_t'(1);
        depth_nxt   = depth_r + len_t'(1);
      end
      ST_QSTART: begin
        cur_nxt     = '0;
        depth_nxt   = '0;
        partner_nxt = '0;
        match_nxt   = (root_r != '0);
      end
      ST_QUERY: begin
        ram_raddr = take_child;
        if (!at_end && !dead_end) begin
          partner_nxt = {partner_r[WORD_BITS-2:0], take};
          cur_nxt     = take_child;
          depth_nxt   = depth_r + len_t'(1);
        end
      end
      ST_DONE: begin
        if (done_fire) begin
          out_valid_nxt = 1'b1;
          out_drop_nxt  = drop_r;
          if (better) begin
            best_valid_nxt  = 1'b1;
            best_first_nxt  = w_r;
            best_second_nxt = partner_r & len_mask;
            best_xor_nxt    = cand_xor;
          end
        end
      end
      default: ;
    endcase

    // Drop the trie and the best pair on a length change.
    if (cfg_we) begin
      len_cfg_nxt     = cfg_wdata;
      root_nxt        = '0;
      cnt_nxt         = cnt_t'(1);
      best_valid_nxt  = 1'b0;
      best_first_nxt  = '0;
      best_second_nxt = '0;
      best_xor_nxt    = '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.best_first  = best_first_r;
  assign out_ch.best_second = best_second_r;
  assign out_ch.best_xor    = best_xor_r;
  assign out_ch.pool_full   = out_drop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      len_cfg_r     <= len_t'(LEN_RESET);
      cnt_r         <= cnt_t'(1);
      root_r        <= '0;
      best_valid_r  <= 1'b0;
      best_first_r  <= '0;
      best_second_r <= '0;
      best_xor_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      len_cfg_r     <= len_cfg_nxt;
      cnt_r         <= cnt_nxt;
      root_r        <= root_nxt;
      best_valid_r  <= best_valid_nxt;
      best_first_r  <= best_first_nxt;
      best_second_r <= best_second_nxt;
      best_xor_r    <= best_xor_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    w_r        <= w_nxt;
    cur_r      <= cur_nxt;
    depth_r    <= depth_nxt;
    partner_r  <= partner_nxt;
    drop_r     <= drop_nxt;
    match_r    <= match_nxt;
    out_drop_r <= out_drop_nxt;
  end

`ifndef ASSERT_OFF
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(NODE_POOL))
    else $error("node count beyond pool");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INSERT) |-> (cnt_r < cnt_t'(NODE_POOL)))
    else $error("node allocated from a full pool");

  a_best_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    (best_valid_r && !cfg_we) |=> (best_xor_r >= $past(best_xor_r)))
    else $error("best xor decreased");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIND || state_r == ST_INSERT || state_r == ST_QUERY)
      |-> (depth_r <= eff_len))
    else $error("walk depth beyond word length");
`endif

endmodule

[rtl/mxp_node_ram.sv]
// Trie node pool: one write port, one read port with registered read data.
// Depends on mxp_pkg.
module mxp_node_ram (
  input  logic             clk,
  input  mxp_pkg::ram_wr_t wr,
  input  mxp_pkg::node_t   raddr,
  output mxp_pkg::links_t  rdata
);
  import mxp_pkg::*;

  links_t mem [NODE_POOL];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

[sim/mxp_pair_checker.sv]
// Best-pair checker: watches the word and result channels and the length register port,
// keeps its own trie and best pair, and compares every result beat field by field.
// Depends on mxp_pkg and the channel interfaces in mxp_stream_if.
module mxp_pair_checker (
  input  logic           clk,
  input  logic           rst_n,
  mxp_in_if              in_ch,
  mxp_out_if             out_ch,
  input  logic           cfg_we,
  input  mxp_pkg::len_t  cfg_wdata,
  output int unsigned    mismatch_count,
  output int unsigned    pending
);
  import mxp_pkg::*;

  typedef struct packed {
    word_t pair_first;
    word_t pair_second;
    word_t pair_xor;
    logic  dropped;
  } pair_beat_t;

  bit [NODE_BITS-1:0] kid [NODE_POOL][2];
  int unsigned        nodes_used;
  bit                 have_best;
  word_t              best_first;
  word_t              best_second;
  word_t              best_xor;
  len_t               len_reg;
  pair_beat_t         best_pair_q[$];
  int unsigned        beat_no;

  task automatic empty_trie();
    kid[0][0] = '0;
    kid[0][1] = '0;
    nodes_used = 1;
    have_best = 1'b0;
    best_first = '0;
    best_second = '0;
    best_xor = '0;
  endtask

  task automatic report(input string what, input word_t got, input word_t want);
    $display("%0t beat %0d mismatch on %s: got %h want %h", $time, beat_no, what, got, want);
    mismatch_count++;
  endtask

  function automatic pair_beat_t insert_and_query(input word_t raw);
    int unsigned len_eff;
    int unsigned depth;
    int unsigned i;
    node_t       cur;
    node_t       fresh;
    word_t       mask;
    word_t       w;
    word_t       partner;
    word_t       x;
    bit          b;
    bit          take;
    bit          stuck;
    bit          dropped;
    pair_beat_t  r;
    len_eff = len_reg;
    if (len_eff < LEN_MIN) len_eff = LEN_MIN;
    if (len_eff > WORD_BITS) len_eff = WORD_BITS;
    mask = word_t'((64'd1 << len_eff) - 1);
    w = raw & mask;
    cur = '0;
    depth = 0;
    while (depth < len_eff && kid[cur][w[len_eff-1-depth]] != '0) begin
      cur = kid[cur][w[len_eff-1-depth]];
      depth++;
    end
    dropped = (nodes_used + len_eff - depth > NODE_POOL);
    if (!dropped) begin
      for (i = depth; i < len_eff; i++) begin
        b = w[len_eff-1-i];
        fresh = node_t'(nodes_used);
        kid[fresh][0] = '0;
        kid[fresh][1] = '0;
        kid[cur][b] = fresh;
        nodes_used++;
        cur = fresh;
      end
    end
    if (kid[0][0] != '0 || kid[0][1] != '0) begin
      partner = '0;
      cur = '0;
      stuck = 1'b0;
      for (i = 0; i < len_eff; i++) begin
        if (!stuck) begin
          b = w[len_eff-1-i];
          take = b;
          if (kid[cur][~b] != '0) take = ~b;
          else if (kid[cur][b] == '0) stuck = 1'b1;
          if (!stuck) begin
            partner = {partner[WORD_BITS-2:0], take};
            cur = kid[cur][take];
          end
        end
      end
      partner = partner & mask;
      x = (w ^ partner) & mask;
      if (!have_best || x > best_xor) begin
        have_best = 1'b1;
        best_first = w;
        best_second = partner;
        best_xor = x;
      end
    end
    r.pair_first = best_first;
    r.pair_second = best_second;
    r.pair_xor = best_xor;
    r.dropped = dropped;
    return r;
  endfunction

  always @(posedge clk) begin
    pair_beat_t want;
    if (!rst_n) begin
      len_reg = len_t'(LEN_RESET);
      empty_trie();
      best_pair_q.delete();
      beat_no = 0;
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        len_reg = cfg_wdata;
        empty_trie();
      end
      if (out_ch.valid && out_ch.ready) begin
        if (best_pair_q.size() == 0) begin
          report("beat with nothing pending", out_ch.best_first, '0);
        end else begin
          want = best_pair_q.pop_front();
          if (out_ch.best_first !== want.pair_first)
            report("best_first", out_ch.best_first, want.pair_first);
          if (out_ch.best_second !== want.pair_second)
            report("best_second", out_ch.best_second, want.pair_second);
          if (out_ch.best_xor !== want.pair_xor)
            report("best_xor", out_ch.best_xor, want.pair_xor);
          if (out_ch.pool_full !== want.dropped)
            report("pool_full", word_t'(out_ch.pool_full), word_t'(want.dropped));
        end
        beat_no++;
      end
      if (in_ch.valid && in_ch.ready)
        best_pair_q.insert(best_pair_q.size(), insert_and_query(in_ch.word));
    end
    pending <= best_pair_q.size();
  end

endmodule

[sim/tb_top.sv]
// Testbench top for max_xor_pair_trie: clock, reset, word stimulus, length register writes
// and result back-pressure; verdict from the checker's mismatch and pending counts.
// Depends on mxp_pkg, mxp_stream_if, the block itself and mxp_pair_checker.
module tb_top;
  import mxp_pkg::*;

  localparam int unsigned LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  len_t        cfg_wdata;
  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned send_idle = 36;
  int unsigned recv_idle = 54;
  word_t       recent[$];

  mxp_in_if  in_ch ();
  mxp_out_if out_ch ();

  max_xor_pair_trie dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  mxp_pair_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_word(input word_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      in_ch.word <= word_t'($urandom);
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.word <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_len(input len_t v);
    hold_until_drained();
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= len_t'($urandom);
  endtask

  function automatic word_t pick_word();
    word_t       w;
    int unsigned k;
    k = $urandom_range(99);
    if (k < 40 || recent.size() == 0) w = word_t'($urandom);
    else if (k < 55) w = recent[$urandom_range(recent.size() - 1)];
    else if (k < 70) w = ~recent[$urandom_range(recent.size() - 1)];
    else if (k < 85) w = word_t'(1) << $urandom_range(WORD_BITS - 1);
    else w = ($urandom_range(1) ? {WORD_BITS{1'b1}} : {WORD_BITS{1'b0}}) ^ word_t'($urandom_range(7));
    return w;
  endfunction

  task automatic run_phase(input len_t v, input int unsigned n, input bit mid_pause);
    word_t w;
    write_len(v);
    for (int unsigned i = 0; i < n; i++) begin
      if (mid_pause && i == n / 2) hold_until_drained();
      w = pick_word();
      recent.insert(recent.size(), w);
      if (recent.size() > 32) void'(recent.pop_front());
      send_word(w);
    end
  endtask

  initial begin
    word_t directed_20 [12];
    word_t directed_3 [6];
    directed_20 = '{20'h00000, 20'h00000, 20'hFFFFF, 20'hFFFFF, 20'h80000, 20'h7FFFF,
                    20'h00001, 20'hAAAAA, 20'h55555, 20'h12345, 20'hEDCBA, 20'h7FFFE};
    directed_3 = '{20'h00000, 20'h00007, 20'hFFFF8, 20'h00005, 20'h00002, 20'hFFFFF};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.word = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_20[i]) send_word(directed_20[i]);
    write_len(len_t'(3));
    foreach (directed_3[i]) send_word(directed_3[i]);

    run_phase(len_t'(3), 50, 1'b0);
    run_phase(len_t'(0), 50, 1'b1);
    run_phase(len_t'(31), 50, 1'b0);
    run_phase(len_t'(12), 50, 1'b0);

    send_idle = 54;
    recv_idle = 36;
    run_phase(len_t'(1), 50, 1'b0);
    run_phase(len_t'(20), 50, 1'b1);
    run_phase(len_t'(7), 50, 1'b0);
    run_phase(len_t'(21), 50, 1'b0);

    send_idle = 0;
    recv_idle = 0;
    run_phase(len_t'(2), 50, 1'b0);
    run_phase(len_t'(17), 50, 1'b0);
    run_phase(len_t'($urandom_range(3, 20)), 50, 1'b1);

    hold_until_drained();
    repeat (48) @(negedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
